// File: hdl/thermal_fan_power_safety_supervisor_assert.svh
// assertion macros shared by the supervisor checker
`ifndef THERMAL_FAN_POWER_SAFETY_SUPERVISOR_ASSERT_SVH
`define THERMAL_FAN_POWER_SAFETY_SUPERVISOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define TFPSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked at every clock edge outside reset
`define TFPSS_ASSERT_IMPLY(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: hdl/tfpss_pkg.sv
`default_nettype none

package tfpss_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMP_LIMIT     = 3'd0;
    localparam logic [2:0] CFG_STALL_PWM      = 3'd1;
    localparam logic [2:0] CFG_STALL_DEBOUNCE = 3'd2;
    localparam logic [2:0] CFG_CUR_INTERCEPT  = 3'd3;
    localparam logic [2:0] CFG_CUR_SLOPE      = 3'd4;
    localparam logic [2:0] CFG_CUR_MARGIN     = 3'd5;
    localparam logic [2:0] CFG_VIN_WARN       = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [11:0] TEMP_LIMIT_RST     = 12'd850;
    localparam logic [9:0]  STALL_PWM_RST      = 10'd512;
    localparam logic [15:0] STALL_DEBOUNCE_RST = 16'd3000;
    localparam logic [14:0] CUR_INTERCEPT_RST  = 15'd0;
    localparam logic [13:0] CUR_SLOPE_RST      = 14'd0;
    localparam logic [12:0] CUR_MARGIN_RST     = 13'd100;
    localparam logic [14:0] VIN_WARN_RST       = 15'd9000;

    // milliamps to microamp-scale for the exact current compare
    localparam logic signed [31:0] MILLI_SCALE = 32'sd1000;

    // warning and error bit positions
    localparam int WARN_SUPPLY_LOST  = 0;
    localparam int WARN_UNDERCURRENT = 1;
    localparam int WARN_LOW_VIN      = 2;
    localparam int ERR_OVERTEMP      = 0;
    localparam int ERR_FAN_STALL     = 1;

    typedef struct packed {
        logic        temp_valid;
        logic [11:0] temp_deci_c;
        logic [9:0]  fan_pwm;
        logic [15:0] fan_speed_rpm;
        logic [9:0]  elapsed_ms;
        logic        supply_ok;
        logic [13:0] supply_current_ma;
        logic [14:0] vin_mv;
    } t_in_item;

    typedef struct packed {
        logic       drive_enable;
        logic [2:0] warnings;
        logic [1:0] errors;
        logic       fault_latched;
    } t_out_item;

    typedef struct packed {
        logic [11:0] temp_limit;
        logic [9:0]  stall_pwm;
        logic [15:0] stall_debounce_ms;
        logic [14:0] current_intercept_ma;
        logic [13:0] current_slope;
        logic [12:0] current_margin_ma;
        logic [14:0] vin_warn_mv;
    } t_cfg;

    // latch flags carried between samples
    typedef struct packed {
        logic overtemp;
        logic stall;
        logic first_good;
    } t_flags;

endpackage

`default_nettype wire

// File: hdl/tfpss_eval.sv
`default_nettype none

module tfpss_eval #(
    parameter int STALL_TIMER_BITS = 16
) (
    input  var tfpss_pkg::t_cfg             i_cfg,
    input  var tfpss_pkg::t_in_item         i_item,
    input  var tfpss_pkg::t_flags           i_flags,
    input  wire [STALL_TIMER_BITS-1:0]      i_timer,
    output tfpss_pkg::t_flags               o_flags,
    output logic [STALL_TIMER_BITS-1:0]     o_timer,
    output tfpss_pkg::t_out_item            o_result
);

    localparam int TB    = STALL_TIMER_BITS;
    localparam int SUM_W = ((TB > 10) ? TB : 10) + 1;
    localparam int CMP_W = (TB > 16) ? TB : 16;
    localparam logic [TB-1:0] TIMER_MAX = {TB{1'b1}};

    logic                    w_hot;
    logic                    w_stalling;
    logic [SUM_W-1:0]        w_sum;
    logic [TB-1:0]           w_sat;
    logic                    w_deb_hit;
    logic signed [31:0]      w_lhs;
    logic signed [31:0]      w_base;
    logic [28:0]             w_prod;
    logic signed [31:0]      w_rhs;
    logic                    w_ot;
    logic                    w_st;
    logic                    w_latched;
    logic                    w_fg;
    logic [2:0]              w_warn;

    // overtemperature: invalid reading or at/above limit
    assign w_hot = !i_item.temp_valid ||
                   ($signed(i_item.temp_deci_c) >= $signed(i_cfg.temp_limit));

    // saturating stall timer
    assign w_stalling = (i_item.fan_pwm >= i_cfg.stall_pwm) && (i_item.fan_speed_rpm == '0);
    assign w_sum      = SUM_W'(i_timer) + SUM_W'(i_item.elapsed_ms);
    assign w_sat      = (w_sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX : w_sum[TB-1:0];
    assign w_deb_hit  = CMP_W'(w_sat) >= CMP_W'(i_cfg.stall_debounce_ms);
    assign o_timer    = w_stalling ? w_sat : '0;

    // latch update, then first good temperature
    assign w_ot      = i_flags.overtemp || w_hot;
    assign w_st      = i_flags.stall || (w_stalling && w_deb_hit);
    assign w_latched = w_ot || w_st;
    assign w_fg      = i_flags.first_good || !w_hot;

    always_comb begin
        o_flags            = '0;
        o_flags.overtemp   = w_ot;
        o_flags.stall      = w_st;
        o_flags.first_good = w_fg;
    end

    // exact undercurrent compare scaled by 1000
    assign w_lhs  = $signed({18'd0, i_item.supply_current_ma}) * tfpss_pkg::MILLI_SCALE;
    assign w_base = ($signed({{17{i_cfg.current_intercept_ma[14]}}, i_cfg.current_intercept_ma})
                     + $signed({19'd0, i_cfg.current_margin_ma})) * tfpss_pkg::MILLI_SCALE;
    assign w_prod = {15'd0, i_cfg.current_slope} * {14'd0, i_item.vin_mv};
    assign w_rhs  = w_base + $signed({3'd0, w_prod});

    // warnings from the current sample only
    always_comb begin
        w_warn = '0;
        w_warn[tfpss_pkg::WARN_SUPPLY_LOST]  = !i_item.supply_ok;
        w_warn[tfpss_pkg::WARN_UNDERCURRENT] = i_item.supply_ok && (w_lhs < w_rhs);
        w_warn[tfpss_pkg::WARN_LOW_VIN]      = i_item.vin_mv < i_cfg.vin_warn_mv;
    end

    // result item
    always_comb begin
        o_result                                  = '0;
        o_result.drive_enable                     = !w_latched && w_fg;
        o_result.warnings                         = w_warn;
        o_result.errors[tfpss_pkg::ERR_OVERTEMP]  = w_ot;
        o_result.errors[tfpss_pkg::ERR_FAN_STALL] = w_st;
        o_result.fault_latched                    = w_latched;
    end

endmodule

`default_nettype wire

// File: hdl/thermal_fan_power_safety_supervisor.sv
// an accepted input transaction goes through the input register, then the result register
// throughput: one per cycle unless the output stalls; input and result register each hold one
// the latch flags and stall timer update as a transaction leaves the input register
// reset (synchronous, active low): pipeline empty, latches, timer and first-good flag cleared,
// configuration registers back to their default values
`default_nettype none

module thermal_fan_power_safety_supervisor #(
    parameter int STALL_TIMER_BITS = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [tfpss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [tfpss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                i_in_valid,
    input  var tfpss_pkg::t_in_item            i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output tfpss_pkg::t_out_item               o_out_data,
    input  wire                                i_out_stall
);

    tfpss_pkg::t_cfg                r_cfg;
    tfpss_pkg::t_in_item            r_s1_data;
    logic                           r_s1_vld;
    tfpss_pkg::t_flags              r_flags;
    logic [STALL_TIMER_BITS-1:0]    r_timer;
    tfpss_pkg::t_out_item           r_out_data;
    logic                           r_out_vld;

    tfpss_pkg::t_flags              n_flags;
    logic [STALL_TIMER_BITS-1:0]    n_timer;
    tfpss_pkg::t_out_item           n_out_data;

    logic                           w_out_free;
    logic                           w_s1_adv;
    logic                           w_in_acc;

    // handshake
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_s1_adv    = r_s1_vld && w_out_free;
    assign o_in_stall  = r_s1_vld && !w_out_free;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_limit           <= tfpss_pkg::TEMP_LIMIT_RST;
            r_cfg.stall_pwm            <= tfpss_pkg::STALL_PWM_RST;
            r_cfg.stall_debounce_ms    <= tfpss_pkg::STALL_DEBOUNCE_RST;
            r_cfg.current_intercept_ma <= tfpss_pkg::CUR_INTERCEPT_RST;
            r_cfg.current_slope        <= tfpss_pkg::CUR_SLOPE_RST;
            r_cfg.current_margin_ma    <= tfpss_pkg::CUR_MARGIN_RST;
            r_cfg.vin_warn_mv          <= tfpss_pkg::VIN_WARN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tfpss_pkg::CFG_TEMP_LIMIT:     r_cfg.temp_limit           <= i_cfg_data[11:0];
                tfpss_pkg::CFG_STALL_PWM:      r_cfg.stall_pwm            <= i_cfg_data[9:0];
                tfpss_pkg::CFG_STALL_DEBOUNCE: r_cfg.stall_debounce_ms    <= i_cfg_data[15:0];
                tfpss_pkg::CFG_CUR_INTERCEPT:  r_cfg.current_intercept_ma <= i_cfg_data[14:0];
                tfpss_pkg::CFG_CUR_SLOPE:      r_cfg.current_slope        <= i_cfg_data[13:0];
                tfpss_pkg::CFG_CUR_MARGIN:     r_cfg.current_margin_ma    <= i_cfg_data[12:0];
                tfpss_pkg::CFG_VIN_WARN:       r_cfg.vin_warn_mv          <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_data <= i_in_data;
        end
    end

    // evaluation of one sample set
    tfpss_eval #(
        .STALL_TIMER_BITS (STALL_TIMER_BITS)
    ) u_eval (
        .i_cfg    (r_cfg),
        .i_item   (r_s1_data),
        .i_flags  (r_flags),
        .i_timer  (r_timer),
        .o_flags  (n_flags),
        .o_timer  (n_timer),
        .o_result (n_out_data)
    );

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_timer <= '0;
        end else if (w_s1_adv) begin
            r_flags <= n_flags;
            r_timer <= n_timer;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tfpss_chk.sv
`default_nettype none
`include "thermal_fan_power_safety_supervisor_assert.svh"

module tfpss_chk (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_cfg_we,
    input wire [tfpss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input wire [tfpss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input wire                                i_in_valid,
    input var tfpss_pkg::t_in_item            i_in_data,
    input wire                                o_in_stall,
    input wire                                o_out_valid,
    input var tfpss_pkg::t_out_item           o_out_data,
    input wire                                i_out_stall
);

    // a stalled result stays put
    `TFPSS_ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "stalled result changed")

    // fault summary agrees with the error latches
    `TFPSS_ASSERT_ALWAYS(a_fault_sum, i_clk, i_rst_n, !o_out_valid || (o_out_data.fault_latched == (o_out_data.errors != 2'b00)), "fault_latched disagrees with errors")

    // drive is never enabled with a fault latched
    `TFPSS_ASSERT_ALWAYS(a_drive_off, i_clk, i_rst_n, !o_out_valid || !(o_out_data.drive_enable && o_out_data.fault_latched), "drive enabled while faulted")

    // an error latch once reported stays set
    `TFPSS_ASSERT_IMPLY(a_err_sticky, i_clk, i_rst_n, (o_out_valid && !i_out_stall && (o_out_data.errors != 2'b00)) |=> (!o_out_valid || (o_out_data.errors != 2'b00)), "error latch cleared without reset")

endmodule

bind thermal_fan_power_safety_supervisor tfpss_chk u_tfpss_chk (.*);

`default_nettype wire
